/* sv/hdta_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package hdta_pkg;

   // mode codes
   localparam logic [1:0] MODE_VALUE   = 2'd0;
   localparam logic [1:0] MODE_TANGENT = 2'd1;
   localparam logic [1:0] MODE_ADJOINT = 2'd2;

   // register indexes
   localparam logic [2:0] REG_CRIT_BASE  = 3'd0;
   localparam logic [2:0] REG_CRIT_SLOPE = 3'd1;
   localparam logic [2:0] REG_PEAK_HAIL  = 3'd2;
   localparam logic [2:0] REG_TEMP_LOW   = 3'd3;
   localparam logic [2:0] REG_TEMP_HIGH  = 3'd4;

   // register reset values
   localparam logic [16:0] CRIT_BASE_RST  = 17'd60293;
   localparam logic [15:0] CRIT_SLOPE_RST = 16'd6554;
   localparam logic [24:0] PEAK_HAIL_RST  = 25'd32985349;
   localparam logic [15:0] TEMP_LOW_RST   = 16'd25315;
   localparam logic [15:0] TEMP_HIGH_RST  = 16'd26815;

   localparam int CSR_DATA_W = 32;

   // magnitude limit of the product-quotient unit
   localparam logic [63:0] WIDE_SAT = 64'h3FFF_FFFF_FFFF_FFFF;

   // request and response of the product-quotient unit
   typedef struct packed {
      logic               start;
      logic signed [63:0] a;
      logic [63:0]        b;
      logic [63:0]        c;
   } md_req_type;

   typedef struct packed {
      logic               done;
      logic signed [63:0] q;
   } md_rsp_type;

   // clamp to 48-bit two's complement
   function automatic logic signed [47:0] sat48(input logic signed [63:0] x);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = 64'sh0000_7FFF_FFFF_FFFF;
      lo = -64'sh0000_8000_0000_0000;
      if (x > hi) return hi[47:0];
      else if (x < lo) return lo[47:0];
      else return x[47:0];
   endfunction

   // clamp magnitude to the unit limit
   function automatic logic signed [63:0] satw(input logic signed [63:0] x);
      logic signed [63:0] lim;
      lim = $signed(WIDE_SAT);
      if (x > lim) return lim;
      else if (x < -lim) return -lim;
      else return x;
   endfunction

   function automatic logic signed [63:0] sx48(input logic signed [47:0] x);
      return {{16{x[47]}}, x};
   endfunction

endpackage
`default_nettype wire

/* sv/hdta_muldiv.sv */
`timescale 1ns / 1ps
`default_nettype none
module hdta_muldiv (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire hdta_pkg::md_req_type req,
   output hdta_pkg::md_rsp_type      rsp
);
   import hdta_pkg::*;

   typedef enum logic [4:0] {
      MD_IDLE = 5'b00001,
      MD_MUL  = 5'b00010,
      MD_CHK  = 5'b00100,
      MD_DIV  = 5'b01000,
      MD_FIN  = 5'b10000
   } md_state_type;

   // divisor that is served by a shift instead of the divide loop
   localparam logic [63:0] SCALE_DIV = 64'h1_0000;

   md_state_type state_ff, state_in;
   logic [5:0]   cnt_ff, cnt_in;
   logic         neg_ff, neg_in;
   logic [63:0]  hi_ff, hi_in;
   logic [63:0]  lo_ff, lo_in;
   logic [63:0]  b_ff, b_in;
   logic [63:0]  c_ff, c_in;

   logic [64:0]  sum;
   logic [64:0]  rr;
   logic [64:0]  diff;
   logic         ge;
   logic [63:0]  mag;

   // shift-add multiply, then restoring divide
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      neg_in   = neg_ff;
      hi_in    = hi_ff;
      lo_in    = lo_ff;
      b_in     = b_ff;
      c_in     = c_ff;
      sum  = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, b_ff} : 65'd0);
      rr   = {hi_ff, lo_ff[63]};
      diff = rr - {1'b0, c_ff};
      ge   = rr >= {1'b0, c_ff};
      mag  = (lo_ff > WIDE_SAT) ? WIDE_SAT : lo_ff;
      rsp.done = 1'b0;
      rsp.q    = neg_ff ? -$signed(mag) : $signed(mag);
      case (state_ff)
         MD_IDLE: begin
            if (req.start) begin
               neg_in   = req.a[63];
               lo_in    = req.a[63] ? 64'(-req.a) : 64'(req.a);
               hi_in    = '0;
               b_in     = req.b;
               c_in     = req.c;
               cnt_in   = '0;
               state_in = MD_MUL;
            end
         end
         MD_MUL: begin
            hi_in  = sum[64:1];
            lo_in  = {sum[0], lo_ff[63:1]};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = MD_CHK;
         end
         MD_CHK: begin
            if (c_ff == 64'd0 || hi_ff >= c_ff) begin
               lo_in    = WIDE_SAT;
               state_in = MD_FIN;
            end else if (c_ff == SCALE_DIV) begin
               // scaling by 2^-16 is a plain shift of the product
               lo_in    = {hi_ff[15:0], lo_ff[63:16]};
               state_in = MD_FIN;
            end else begin
               cnt_in   = '0;
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            hi_in  = ge ? diff[63:0] : rr[63:0];
            lo_in  = {lo_ff[62:0], ge};
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd63) state_in = MD_FIN;
         end
         MD_FIN: begin
            rsp.done = 1'b1;
            state_in = MD_IDLE;
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
      hi_ff  <= hi_in;
      lo_ff  <= lo_in;
      b_ff   <= b_in;
      c_ff   <= c_in;
   end

endmodule
`default_nettype wire

/* sv/hail_diagnostic_with_tangent_adjoint_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// Hail diagnostic with tangent-linear and adjoint forms, one level per transaction.
// Every step is an exact a*b/c in one shared product-quotient unit that runs
// a shift-add multiply and then a restoring divide; a step that scales by
// 2^-16, meets a zero divisor or has a quotient that would overflow skips
// the divide. Mode 3 and inactive levels take one step; active mode 0 levels
// take two; active tangent and adjoint levels take six full steps and one
// scaling step. The block takes one transaction at a time; a finished
// result waits in an output register. The surface adjoint sum is kept
// between adjoint transactions and is loaded from pert_surface when
// column_start is set.
module hail_diagnostic_with_tangent_adjoint_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [2:0]                        csr_index,
   input  wire logic [hdta_pkg::CSR_DATA_W-1:0]   csr_data,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [1:0]                        req_mode,
   input  wire logic [15:0]                       req_temperature,
   input  wire logic [16:0]                       req_pressure,
   input  wire logic [16:0]                       req_humidity,
   input  wire logic [16:0]                       req_surface_pressure,
   input  wire logic signed [47:0]                req_pert_pressure,
   input  wire logic signed [47:0]                req_pert_humidity,
   input  wire logic signed [47:0]                req_pert_surface,
   input  wire logic signed [47:0]                req_hail_adjoint,
   input  wire logic                              req_column_start,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [47:0]                     rsp_hail_value,
   output logic signed [47:0]                     rsp_pressure_adjoint,
   output logic signed [47:0]                     rsp_humidity_adjoint,
   output logic signed [47:0]                     rsp_surface_adjoint,
   output logic                                   rsp_active
);
   import hdta_pkg::*;

   typedef enum logic [16:0] {
      S_IDLE = 17'b00000000000000001,
      S_CRIT = 17'b00000000000000010,
      S_DEC  = 17'b00000000000000100,
      S_M0   = 17'b00000000000001000,
      S_T1   = 17'b00000000000010000,
      S_T2   = 17'b00000000000100000,
      S_DC   = 17'b00000000001000000,
      S_TA   = 17'b00000000010000000,
      S_QS   = 17'b00000000100000000,
      S_TB   = 17'b00000001000000000,
      S_HDA  = 17'b00000010000000000,
      S_G1   = 17'b00000100000000000,
      S_G    = 17'b00001000000000000,
      S_K    = 17'b00010000000000000,
      S_PA   = 17'b00100000000000000,
      S_SUM  = 17'b01000000000000000,
      S_OUT  = 17'b10000000000000000
   } state_type;

   localparam logic [63:0] ONE32 = 64'h1_0000_0000;
   localparam logic [63:0] TWO16 = 64'h1_0000;

   // configuration registers
   logic [16:0] crit_base_ff;
   logic [15:0] crit_slope_ff;
   logic [24:0] peak_ff;
   logic [15:0] temp_low_ff;
   logic [15:0] temp_high_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         crit_base_ff  <= CRIT_BASE_RST;
         crit_slope_ff <= CRIT_SLOPE_RST;
         peak_ff       <= PEAK_HAIL_RST;
         temp_low_ff   <= TEMP_LOW_RST;
         temp_high_ff  <= TEMP_HIGH_RST;
      end else if (csr_valid) begin
         case (csr_index)
            REG_CRIT_BASE:  crit_base_ff  <= csr_data[16:0];
            REG_CRIT_SLOPE: crit_slope_ff <= csr_data[15:0];
            REG_PEAK_HAIL:  peak_ff       <= csr_data[24:0];
            REG_TEMP_LOW:   temp_low_ff   <= csr_data[15:0];
            REG_TEMP_HIGH:  temp_high_ff  <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // captured transaction and working registers
   state_type          state_ff, state_in;
   logic               issued_ff, issued_in;
   logic [1:0]         mode_ff;
   logic [15:0]        t_ff;
   logic [16:0]        p_ff, rh_ff, ps_ff;
   logic signed [47:0] pp_ff, ph_ff, pst_ff, ha_ff;
   logic               start_ff;
   logic [33:0]        pssq_ff;
   logic [49:0]        c32_ff, c32_in;
   logic signed [63:0] r1_ff, r1_in, r2_ff, r2_in;
   logic signed [47:0] sum_ff, sum_in;
   logic signed [47:0] hv_ff, hv_in, pa_ff, pa_in, hda_ff, hda_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [47:0] rsp_hv_ff, rsp_pa_ff, rsp_hda_ff, rsp_sa_ff;
   logic               rsp_act_ff;

   md_req_type md_req;
   md_rsp_type md_rsp;

   hdta_muldiv u_muldiv (
      .clock (clock),
      .reset (reset),
      .req   (md_req),
      .rsp   (md_rsp)
   );

   // level condition and derived fractions
   logic [32:0] rh32;
   logic        above;
   logic        act;
   logic [32:0] d32;
   logic [32:0] om;
   logic        out_free;

   always_comb begin
      rh32  = {rh_ff, 16'd0};
      above = {31'd0, rh32} > ONE32;
      act   = (ps_ff != 17'd0) && (t_ff > temp_low_ff) && (t_ff < temp_high_ff) &&
              ({14'd0, c32_ff} < ONE32) && ({17'd0, rh32} > c32_ff);
      d32   = 33'(ONE32) - c32_ff[32:0];
      om    = above ? rh32 - 33'(ONE32) : 33'(ONE32) - rh32;
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);

   // sequencer
   always_comb begin
      state_in  = state_ff;
      issued_in = issued_ff;
      c32_in    = c32_ff;
      r1_in     = r1_ff;
      r2_in     = r2_ff;
      sum_in    = sum_ff;
      hv_in     = hv_ff;
      pa_in     = pa_ff;
      hda_in    = hda_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      md_req.start = 1'b0;
      md_req.a     = '0;
      md_req.b     = '0;
      md_req.c     = '0;

      // operand select for each step
      case (state_ff)
         S_CRIT: begin
            md_req.a = $signed({48'd0, crit_slope_ff});
            md_req.b = {31'd0, p_ff, 16'd0};
            md_req.c = {47'd0, ps_ff};
         end
         S_M0: begin
            md_req.a = $signed({14'd0, {17'd0, rh32} - c32_ff});
            md_req.b = {39'd0, peak_ff};
            md_req.c = {31'd0, d32};
         end
         S_T1: begin
            md_req.a = sx48(pp_ff);
            md_req.b = ONE32;
            md_req.c = {47'd0, ps_ff};
         end
         S_T2: begin
            md_req.a = sx48(pst_ff);
            md_req.b = {15'd0, p_ff, 32'd0};
            md_req.c = {30'd0, pssq_ff};
         end
         S_DC: begin
            md_req.a = r1_ff;
            md_req.b = {48'd0, crit_slope_ff};
            md_req.c = TWO16;
         end
         S_TA: begin
            md_req.a = sx48(ph_ff);
            md_req.b = {31'd0, peak_ff, 8'd0};
            md_req.c = {31'd0, d32};
         end
         S_QS: begin
            md_req.a = r1_ff;
            md_req.b = {31'd0, om};
            md_req.c = {31'd0, d32};
         end
         S_TB: begin
            md_req.a = above ? -r1_ff : r1_ff;
            md_req.b = {39'd0, peak_ff};
            md_req.c = {23'd0, d32, 8'd0};
         end
         S_HDA: begin
            md_req.a = sx48(ha_ff);
            md_req.b = {31'd0, peak_ff, 8'd0};
            md_req.c = {31'd0, d32};
         end
         S_G1: begin
            md_req.a = sx48(ha_ff);
            md_req.b = {39'd0, peak_ff};
            md_req.c = {23'd0, d32, 8'd0};
         end
         S_G: begin
            md_req.a = r1_ff;
            md_req.b = {31'd0, om};
            md_req.c = {31'd0, d32};
         end
         S_K: begin
            md_req.a = above ? r1_ff : -r1_ff;
            md_req.b = {48'd0, crit_slope_ff};
            md_req.c = TWO16;
         end
         S_PA: begin
            md_req.a = r1_ff;
            md_req.b = ONE32;
            md_req.c = {47'd0, ps_ff};
         end
         S_SUM: begin
            md_req.a = r1_ff;
            md_req.b = {15'd0, p_ff, 32'd0};
            md_req.c = {30'd0, pssq_ff};
         end
         default: ;
      endcase

      // issue once per step
      if (state_ff != S_IDLE && state_ff != S_DEC && state_ff != S_OUT) begin
         md_req.start = !issued_ff;
         issued_in    = 1'b1;
      end

      case (state_ff)
         S_IDLE: begin
            issued_in = 1'b0;
            if (req_valid) state_in = S_CRIT;
         end
         S_CRIT: begin
            if (md_rsp.done) begin
               c32_in    = {17'd0, crit_base_ff, 16'd0} + md_rsp.q[49:0];
               issued_in = 1'b0;
               state_in  = S_DEC;
            end
         end
         S_DEC: begin
            hv_in  = '0;
            pa_in  = '0;
            hda_in = '0;
            case (mode_ff)
               MODE_VALUE:   state_in = act ? S_M0 : S_OUT;
               MODE_TANGENT: state_in = act ? S_T1 : S_OUT;
               MODE_ADJOINT: begin
                  if (start_ff) sum_in = pst_ff;
                  if (act) begin
                     state_in = S_HDA;
                  end else begin
                     hv_in    = ha_ff;
                     pa_in    = pp_ff;
                     hda_in   = ph_ff;
                     state_in = S_OUT;
                  end
               end
               default: state_in = S_OUT;
            endcase
         end
         S_M0: if (md_rsp.done) begin
            hv_in = sat48(md_rsp.q); issued_in = 1'b0; state_in = S_OUT;
         end
         S_T1: if (md_rsp.done) begin
            r1_in = md_rsp.q; issued_in = 1'b0; state_in = S_T2;
         end
         S_T2: if (md_rsp.done) begin
            r1_in = satw(r1_ff - md_rsp.q); issued_in = 1'b0; state_in = S_DC;
         end
         S_DC: if (md_rsp.done) begin
            r1_in = md_rsp.q; issued_in = 1'b0; state_in = S_TA;
         end
         S_TA: if (md_rsp.done) begin
            r2_in = md_rsp.q; issued_in = 1'b0; state_in = S_QS;
         end
         S_QS: if (md_rsp.done) begin
            r1_in = md_rsp.q; issued_in = 1'b0; state_in = S_TB;
         end
         S_TB: if (md_rsp.done) begin
            hv_in = sat48(r2_ff - md_rsp.q); issued_in = 1'b0; state_in = S_OUT;
         end
         S_HDA: if (md_rsp.done) begin
            hda_in = sat48(sx48(ph_ff) + md_rsp.q); issued_in = 1'b0; state_in = S_G1;
         end
         S_G1: if (md_rsp.done) begin
            r1_in = md_rsp.q; issued_in = 1'b0; state_in = S_G;
         end
         S_G: if (md_rsp.done) begin
            r1_in = md_rsp.q; issued_in = 1'b0; state_in = S_K;
         end
         S_K: if (md_rsp.done) begin
            r1_in = md_rsp.q; issued_in = 1'b0; state_in = S_PA;
         end
         S_PA: if (md_rsp.done) begin
            pa_in = sat48(sx48(pp_ff) + md_rsp.q); issued_in = 1'b0; state_in = S_SUM;
         end
         S_SUM: if (md_rsp.done) begin
            sum_in = sat48(sx48(sum_ff) - md_rsp.q); issued_in = 1'b0; state_in = S_OUT;
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sum_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
      end
   end

   // transaction capture and datapath
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         mode_ff  <= req_mode;
         t_ff     <= req_temperature;
         p_ff     <= req_pressure;
         rh_ff    <= req_humidity;
         ps_ff    <= req_surface_pressure;
         pp_ff    <= req_pert_pressure;
         ph_ff    <= req_pert_humidity;
         pst_ff   <= req_pert_surface;
         ha_ff    <= req_hail_adjoint;
         start_ff <= req_column_start;
         pssq_ff  <= req_surface_pressure * req_surface_pressure;
      end
      c32_ff <= c32_in;
      r1_ff  <= r1_in;
      r2_ff  <= r2_in;
      hv_ff  <= hv_in;
      pa_ff  <= pa_in;
      hda_ff <= hda_in;
   end

   // result register
   always_ff @(posedge clock) begin
      if (state_ff == S_OUT && out_free) begin
         rsp_hv_ff  <= hv_ff;
         rsp_pa_ff  <= pa_ff;
         rsp_hda_ff <= hda_ff;
         rsp_sa_ff  <= (mode_ff == MODE_ADJOINT) ? sum_ff : '0;
         rsp_act_ff <= act && (mode_ff == MODE_VALUE || mode_ff == MODE_TANGENT ||
                               mode_ff == MODE_ADJOINT);
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_hail_value       = rsp_hv_ff;
   assign rsp_pressure_adjoint = rsp_pa_ff;
   assign rsp_humidity_adjoint = rsp_hda_ff;
   assign rsp_surface_adjoint  = rsp_sa_ff;
   assign rsp_active           = rsp_act_ff;

endmodule
`default_nettype wire
